// File: rtl/selection_sort_engine_unit_assert.svh
// assertion macros shared by the checker of the selection sort engine
`ifndef SELECTION_SORT_ENGINE_UNIT_ASSERT_SVH
`define SELECTION_SORT_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SSORT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssort check failed");

// next-cycle implication, checked out of reset
`define SSORT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssort check failed");

`endif

// File: rtl/ssort_pkg.sv
// shared constants, controller states and command/status types of the sort engine
package ssort_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_RD_POS,
        ST_PASS_INIT,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_HOLD
    } ssort_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic store_item;
        logic start_sort;
        logic read_pos;
        logic init_pass;
        logic scan_step;
        logic write_min;
        logic write_held;
        logic read_emit;
        logic load_out;
        logic next_emit;
        logic clear_run;
    } ssort_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic more_than_one;
        logic scan_done;
        logic pass_last;
        logic emit_last;
    } ssort_status_t;

endpackage

// File: rtl/ssort_ctrl.sv
// controller state machine of the sort engine: load, sort passes, emit
module ssort_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic                     item_last,
    input  logic                     sorted_ready,
    input  ssort_pkg::ssort_status_t status,
    output logic                     item_ready,
    output logic                     sorted_valid,
    output ssort_pkg::ssort_cmd_t    cmd
);
    import ssort_pkg::*;

    ssort_state_t state_reg;
    ssort_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (item_valid && item_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = status.more_than_one ? ST_RD_POS : ST_EMIT_RD;
            end
            ST_RD_POS:    state_next = ST_PASS_INIT;
            ST_PASS_INIT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_SWAP_A;
                end
            end
            ST_SWAP_A:    state_next = ST_SWAP_B;
            ST_SWAP_B:
            begin
                state_next = status.pass_last ? ST_EMIT_RD : ST_RD_POS;
            end
            ST_EMIT_RD:   state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD: state_next = ST_EMIT_HOLD;
            ST_EMIT_HOLD:
            begin
                if (sorted_ready)
                begin
                    state_next = status.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_LOAD;
        endcase
    end

    // command and handshake outputs
    always_comb
    begin
        cmd          = '0;
        item_ready   = 1'b0;
        sorted_valid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                item_ready     = 1'b1;
                cmd.store_item = item_valid;
            end
            ST_START:     cmd.start_sort = 1'b1;
            ST_RD_POS:    cmd.read_pos   = 1'b1;
            ST_PASS_INIT: cmd.init_pass  = 1'b1;
            ST_SCAN:      cmd.scan_step  = 1'b1;
            ST_SWAP_A:    cmd.write_min  = 1'b1;
            ST_SWAP_B:    cmd.write_held = 1'b1;
            ST_EMIT_RD:   cmd.read_emit  = 1'b1;
            ST_EMIT_LOAD: cmd.load_out   = 1'b1;
            ST_EMIT_HOLD:
            begin
                sorted_valid = 1'b1;
                if (sorted_ready)
                begin
                    cmd.clear_run = status.emit_last;
                    cmd.next_emit = !status.emit_last;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/ssort_dp.sv
// datapath of the sort engine: item store, pass counters, running minimum, output register
module ssort_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ssort_pkg::ssort_cmd_t                 cmd,
    input  logic signed [ssort_pkg::DATA_W-1:0]   item_value,
    output ssort_pkg::ssort_status_t              status,
    output logic signed [ssort_pkg::DATA_W-1:0]   sorted_value,
    output logic                                  sorted_last,
    output logic                                  overflowed
);
    import ssort_pkg::*;

    logic [DATA_W-1:0] store_mem [MAX_ITEMS];
    logic [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic [CNT_W-1:0]  count_reg;
    logic              overflow_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [IDX_W-1:0]  emit_reg;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] held_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;
    logic              room;
    logic              is_less;

    assign room    = (count_reg < CNT_W'(MAX_ITEMS));
    assign is_less = ($signed(rd_data_reg) < $signed(min_reg));

    // status toward the controller
    assign status.more_than_one = (count_reg >= CNT_W'(2));
    assign status.scan_done     = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);
    assign status.pass_last     = ((CNT_W'(pos_reg) + CNT_W'(2)) >= count_reg);
    assign status.emit_last     = ((CNT_W'(emit_reg) + CNT_W'(1)) == count_reg);

    // read address select
    always_comb
    begin
        if (cmd.read_pos)
        begin
            rd_addr = pos_reg;
        end
        else if (cmd.init_pass)
        begin
            rd_addr = pos_reg + IDX_W'(1);
        end
        else if (cmd.scan_step)
        begin
            rd_addr = scan_reg + IDX_W'(1);
        end
        else if (cmd.read_emit)
        begin
            rd_addr = emit_reg;
        end
        else
        begin
            rd_addr = pos_reg;
        end
    end

    // write port select: new item, minimum into place, displaced value into pick slot
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = min_reg;
        if (cmd.store_item)
        begin
            wr_en   = room;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = item_value;
        end
        else if (cmd.write_min)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg;
            wr_data = min_reg;
        end
        else if (cmd.write_held)
        begin
            wr_en   = 1'b1;
            wr_addr = pick_reg;
            wr_data = held_reg;
        end
    end

    // item store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // run count and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.clear_run)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.store_item)
        begin
            if (room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // pass, scan, pick and emit indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            scan_reg <= '0;
            pick_reg <= '0;
            emit_reg <= '0;
        end
        else
        begin
            if (cmd.start_sort)
            begin
                pos_reg  <= '0;
                emit_reg <= '0;
            end
            if (cmd.init_pass)
            begin
                pick_reg <= pos_reg;
                scan_reg <= pos_reg + IDX_W'(1);
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
                if (is_less)
                begin
                    pick_reg <= scan_reg;
                end
            end
            if (cmd.write_held)
            begin
                pos_reg <= pos_reg + IDX_W'(1);
            end
            if (cmd.next_emit)
            begin
                emit_reg <= emit_reg + IDX_W'(1);
            end
        end
    end

    // running minimum, value displaced from the pass position, output payload
    always_ff @(posedge clk)
    begin
        if (cmd.init_pass)
        begin
            held_reg <= rd_data_reg;
            min_reg  <= rd_data_reg;
        end
        else if (cmd.scan_step && is_less)
        begin
            min_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            out_value_reg <= rd_data_reg;
            out_last_reg  <= status.emit_last;
        end
    end

    assign sorted_value = $signed(out_value_reg);
    assign sorted_last  = out_last_reg;
    assign overflowed   = overflow_reg;

endmodule

// File: rtl/selection_sort_engine_unit.sv
// Selection sort engine: input items load one per cycle while item_ready is high; the last
// item starts the sort. Each scan does one compare a cycle through the single read port of
// the item store. Each result is then read from the store, loaded into the output register
// and held until sorted_ready takes it; the next result is not fetched before that.
// Reset (rst_n, async) empties the run and clears the controller; store contents are kept.
module selection_sort_engine_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic signed [ssort_pkg::DATA_W-1:0] item_value,
    input  logic                                item_last,
    output logic                                sorted_valid,
    input  logic                                sorted_ready,
    output logic signed [ssort_pkg::DATA_W-1:0] sorted_value,
    output logic                                sorted_last,
    output logic                                overflowed
);
    import ssort_pkg::*;

    ssort_cmd_t    cmd;
    ssort_status_t status;

    // controller
    ssort_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_last    (item_last),
        .sorted_ready (sorted_ready),
        .status       (status),
        .item_ready   (item_ready),
        .sorted_valid (sorted_valid),
        .cmd          (cmd)
    );

    // datapath
    ssort_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_value   (item_value),
        .status       (status),
        .sorted_value (sorted_value),
        .sorted_last  (sorted_last),
        .overflowed   (overflowed)
    );

endmodule

// File: rtl/ssort_checker.sv
// port-level checker of the sort engine and its bind to the top level
`include "selection_sort_engine_unit_assert.svh"

module ssort_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_ready,
    input logic                                item_last,
    input logic                                sorted_valid,
    input logic                                sorted_ready,
    input logic signed [ssort_pkg::DATA_W-1:0] sorted_value,
    input logic                                sorted_last,
    input logic                                overflowed
);
    import ssort_pkg::*;

    logic [DATA_W+1:0] out_word;

    // result payload gathered for the hold check
    assign out_word = {sorted_value, sorted_last, overflowed};

    // loading and emitting never overlap
    `SSORT_ASSERT_NOW(a_no_overlap, item_ready, !sorted_valid)
    // a stalled result keeps its payload
    `SSORT_ASSERT_NEXT(a_out_hold, sorted_valid && !sorted_ready, sorted_valid && $stable(out_word))
    // a value that does not end the run leaves the block still loading
    `SSORT_ASSERT_NEXT(a_keep_loading, item_valid && item_ready && !item_last, item_ready)
    // the final result of a run reopens the input
    `SSORT_ASSERT_NEXT(a_run_reopen, sorted_valid && sorted_ready && sorted_last, item_ready && !overflowed)

endmodule

bind selection_sort_engine_unit ssort_checker u_ssort_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_last    (item_last),
    .sorted_valid (sorted_valid),
    .sorted_ready (sorted_ready),
    .sorted_value (sorted_value),
    .sorted_last  (sorted_last),
    .overflowed   (overflowed)
);

// File: tb/tb_selection_sort_engine_unit.sv
// self-checking testbench for the selection sort engine: random runs, stalls, overflow runs
module tb_selection_sort_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ssort_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        bit                       wait_drained;
    } load_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     dropped;
    } sorted_result_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_ready;
    logic signed [DATA_W-1:0] item_value   = '0;
    logic                     item_last    = 1'b0;
    logic                     sorted_valid;
    logic                     sorted_ready = 1'b0;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     sorted_last;
    logic                     overflowed;

    load_item_t     load_pending_q[$];
    sorted_result_t sorted_expect_q[$];

    // run held by the predictor
    logic signed [DATA_W-1:0] run_store [MAX_ITEMS];
    int                       run_count   = 0;
    bit                       run_dropped = 1'b0;

    int error_count = 0;

    // sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pacing
    int hold_left     = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    int stall_phase   = 0;
    int results_taken = 0;

    selection_sort_engine_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_value   (item_value),
        .item_last    (item_last),
        .sorted_valid (sorted_valid),
        .sorted_ready (sorted_ready),
        .sorted_value (sorted_value),
        .sorted_last  (sorted_last),
        .overflowed   (overflowed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // store one accepted item; on the last one sort the run and queue its results
    function automatic void absorb_item(logic signed [DATA_W-1:0] value, logic last);
        int                       pos;
        int                       scan;
        int                       pick;
        int                       k;
        logic signed [DATA_W-1:0] held;
        sorted_result_t           res;
        if (run_count < MAX_ITEMS)
        begin
            run_store[run_count] = value;
            run_count = run_count + 1;
        end
        else
            run_dropped = 1'b1;
        if (last)
        begin
            for (pos = 0; pos + 1 < run_count; pos++)
            begin
                pick = pos;
                for (scan = pos + 1; scan < run_count; scan++)
                    if (run_store[scan] < run_store[pick])
                        pick = scan;
                held = run_store[pos];
                run_store[pos] = run_store[pick];
                run_store[pick] = held;
            end
            for (k = 0; k < run_count; k++)
            begin
                res.value   = run_store[k];
                res.last    = (k + 1 == run_count);
                res.dropped = run_dropped;
                sorted_expect_q.push_back(res);
            end
            run_count   = 0;
            run_dropped = 1'b0;
        end
    endfunction

    function automatic void add_item(logic signed [DATA_W-1:0] value, logic last,
                                     bit wait_drained);
        load_item_t it;
        it.value        = value;
        it.last         = last;
        it.wait_drained = wait_drained;
        load_pending_q.push_back(it);
    endfunction

    // driver: offers pending items in bursts, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_value <= '0;
            item_last  <= 1'b0;
            burst_left = $urandom_range(1, 12);
            gap_left   = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                absorb_item(item_value, item_last);
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (load_pending_q.size() != 0 &&
                         !(load_pending_q[0].wait_drained && sorted_expect_q.size() != 0))
                begin
                    item_valid <= 1'b1;
                    item_value <= load_pending_q[0].value;
                    item_last  <= load_pending_q[0].last;
                    void'(load_pending_q.pop_front());
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        // some bursts run long, and some have no gap after them
                        burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes over time, with a few long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_ready <= 1'b0;
            hold_left     = 0;
            stall_mode    = 0;
            mode_left     = 30;
            stall_phase   = 0;
            results_taken = 0;
        end
        else
        begin
            if (sorted_valid && sorted_ready)
            begin
                results_taken = results_taken + 1;
                if (results_taken == 6 || results_taken == 60 || results_taken == 150)
                    hold_left = 500;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 80);
            end
            else
                mode_left = mode_left - 1;
            stall_phase = (stall_phase + 1) % 4;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                sorted_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       sorted_ready <= 1'b1;
                    1:       sorted_ready <= ($urandom_range(0, 1) == 0);
                    2:       sorted_ready <= ($urandom_range(0, 4) != 0);
                    default: sorted_ready <= (stall_phase == 0);
                endcase
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        sorted_result_t want;
        if (rst_n && sorted_valid && sorted_ready)
        begin
            if (sorted_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %0d last %0b ovf %0b",
                         $time, sorted_value, sorted_last, overflowed);
                error_count = error_count + 1;
            end
            else
            begin
                want = sorted_expect_q.pop_front();
                if (sorted_value !== want.value)
                begin
                    $display("%0t: sorted_value expected %0d, got %0d",
                             $time, want.value, sorted_value);
                    error_count = error_count + 1;
                end
                if (sorted_last !== want.last)
                begin
                    $display("%0t: sorted_last expected %0b, got %0b",
                             $time, want.last, sorted_last);
                    error_count = error_count + 1;
                end
                if (overflowed !== want.dropped)
                begin
                    $display("%0t: overflowed expected %0b, got %0b",
                             $time, want.dropped, overflowed);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int                       i;
        int                       kind;
        int                       style;
        int                       run_len;
        int                       random_items;
        bit                       drain;
        logic signed [DATA_W-1:0] v;

        // single-value runs at both extremes
        add_item(32'sh7FFF_FFFF, 1'b1, 1'b0);
        add_item(32'sh8000_0000, 1'b1, 1'b0);
        // short run mixing extremes, zero and minus one
        add_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
        add_item(32'sh8000_0000, 1'b0, 1'b0);
        add_item(32'sh0000_0000, 1'b0, 1'b0);
        add_item(32'shFFFF_FFFF, 1'b1, 1'b0);
        // full store in reverse order with equal values, then a dropped last value
        for (i = 0; i < MAX_ITEMS; i++)
        begin
            v = (i < 2) ? 32'sh7FFF_FFFF : 32'sd100 - 13 * i;
            add_item(v, 1'b0, i == 0);
        end
        add_item(32'sh8000_0000, 1'b1, 1'b0);

        // random runs, mostly within capacity
        random_items = 0;
        while (random_items < 220)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                run_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
            else if (kind == 1)
                run_len = MAX_ITEMS;
            else if (kind < 4)
                run_len = $urandom_range(1, 3);
            else
                run_len = $urandom_range(4, MAX_ITEMS - 1);
            style = $urandom_range(0, 3);
            drain = ($urandom_range(0, 4) == 0);
            for (i = 0; i < run_len; i++)
            begin
                case (style)
                    0: v = $urandom;
                    1:
                    begin
                        // narrow range gives many equal values
                        v = $urandom_range(0, 8);
                        v = v - 4;
                    end
                    2:
                    begin
                        case ($urandom_range(0, 4))
                            0:       v = 32'sh8000_0000;
                            1:       v = 32'sh7FFF_FFFF;
                            2:       v = 32'sh0000_0000;
                            3:       v = 32'shFFFF_FFFF;
                            default: v = $urandom;
                        endcase
                    end
                    default: v = 32'sd1000 - 37 * i;
                endcase
                add_item(v, i == run_len - 1, drain && i == 0);
            end
            random_items = random_items + run_len;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (load_pending_q.size() != 0 || item_valid)
            @(posedge clk);
        while (sorted_expect_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (error_count == 0 && sorted_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: selection_sort_engine_unit.f
+incdir+rtl
rtl/ssort_pkg.sv
rtl/ssort_ctrl.sv
rtl/ssort_dp.sv
rtl/selection_sort_engine_unit.sv
rtl/ssort_checker.sv
tb/tb_selection_sort_engine_unit.sv
